>>> rtl/core/dda_pkg.sv
`timescale 1ns / 1ps

package dda_pkg;

	// Port field widths
	localparam int PIX_W    = 12;
	localparam int COLOUR_W = 4;
	localparam int STEPS_W  = 13;

	// Defaults for the top-level parameters
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [COLOUR_W-1:0] COLOUR_RESET = 4'd14;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// Status from the shared divider back to the sequencer
	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

endpackage

>>> rtl/core/dda_if.sv
`timescale 1ns / 1ps

interface dda_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [dda_pkg::PIX_W-1:0]  start_x;
	logic [dda_pkg::PIX_W-1:0]  start_y;
	logic [dda_pkg::PIX_W-1:0]  end_x;
	logic [dda_pkg::PIX_W-1:0]  end_y;

	modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_pix_if;
	logic                         valid;
	logic                         ready;
	logic                         pixel_valid;
	logic [dda_pkg::PIX_W-1:0]    pixel_x;
	logic [dda_pkg::PIX_W-1:0]    pixel_y;
	logic [dda_pkg::COLOUR_W-1:0] pixel_colour_out;
	logic                         last_pixel;

	modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_colour_out, last_pixel,
		input ready);
	modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_colour_out, last_pixel,
		output ready);
endinterface

interface dda_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [dda_pkg::COLOUR_W-1:0] pixel_colour;

	modport source (output valid, pixel_colour, input ready);
	modport sink   (input valid, pixel_colour, output ready);
endinterface

>>> rtl/core/dda_line_rasterizer_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                          Handshake
// cmd      in   op, start_x, start_y, end_x, end_y               valid/ready
// pix      out  pixel_valid, pixel_x, pixel_y,                   valid/ready
//               pixel_colour_out, last_pixel
// cfg      in   pixel_colour                                     valid/ready (ready held high)
//
// An advance item returns its pixel in the output register the next cycle;
// advances stream at one per cycle while the sequencer is idle and pix keeps up.
// A start item emits the first pixel at once; for a line of non-zero length it then
// holds cmd.ready low while the shared restoring divider forms the x and then
// the y increment, one quotient bit per cycle.
// arst_n clears the sequencer, the line-active flag, the output valid and sets
// the colour to 14. A stalled pix channel holds its item and blocks cmd only
// when the output register is full and not being drained.

module dda_line_rasterizer_core #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dda_cmd_if.sink     cmd,
	dda_pix_if.source   pix,
	dda_cfg_if.sink     cfg
);
	import dda_pkg::*;

	localparam int ACC_W  = COORD_BITS + FRAC_BITS;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int EXT_W  = (COORD_BITS > PIX_W) ? COORD_BITS : PIX_W;
	localparam int NEXT_W = (COORD_BITS > STEPS_W) ? COORD_BITS : STEPS_W;

	// Sequencer: idle, dividing for x, dividing for y
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIVX = 3'b010,
		S_DIVY = 3'b100
	} state_t;

	state_t                 state_q;
	logic                   go_q;

	// Line state
	logic [ACC_W-1:0]       x_acc_q, y_acc_q;
	logic [STEP_W-1:0]      x_step_q, y_step_q;
	logic [STEPS_W-1:0]     steps_q;
	logic                   active_q;
	logic [COORD_BITS-1:0]  adx_q, ady_q, n_q;
	logic                   xneg_q, yneg_q;
	logic [COLOUR_W-1:0]    colour_q;

	// Output register
	logic                   out_valid_q;
	logic                   pv_q;
	logic [PIX_W-1:0]       px_q, py_q;
	logic [COLOUR_W-1:0]    pc_q;
	logic                   pl_q;

	// Start-item decode
	logic [EXT_W-1:0]       sx_ext, sy_ext, ex_ext, ey_ext;
	logic [COORD_BITS-1:0]  x0_c, y0_c, x1_c, y1_c;
	logic [COORD_BITS-1:0]  adx_c, ady_c, n_c;
	logic                   xneg_c, yneg_c;
	logic [NEXT_W-1:0]      n_ext;
	logic [STEPS_W-1:0]     n_steps;
	logic [EXT_W-1:0]       x0_pix, y0_pix;

	// Advance path
	logic [ACC_W-1:0]       x_acc_n, y_acc_n;
	logic [STEPS_W-1:0]     steps_dec;
	logic                   adv_ok, adv_last;
	logic [EXT_W-1:0]       xa_pix, ya_pix;

	// Divider hookup
	logic [COORD_BITS-1:0]  div_mag;
	logic [FRAC_BITS:0]     div_quot;
	div_stat_t              div_stat;
	logic                   div_neg;
	logic [STEP_W-1:0]      q_ext, step_fix;

	logic                   cmd_acc, is_start;

	assign cmd.ready = (state_q == S_IDLE) && (!out_valid_q || pix.ready);
	assign cfg.ready = 1'b1;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign is_start  = (op_t'(cmd.op) == OP_START);

	// Endpoints are taken modulo 2^COORD_BITS; deltas as magnitude plus sign.
	always_comb begin
		sx_ext  = EXT_W'(cmd.start_x);
		sy_ext  = EXT_W'(cmd.start_y);
		ex_ext  = EXT_W'(cmd.end_x);
		ey_ext  = EXT_W'(cmd.end_y);
		x0_c    = sx_ext[COORD_BITS-1:0];
		y0_c    = sy_ext[COORD_BITS-1:0];
		x1_c    = ex_ext[COORD_BITS-1:0];
		y1_c    = ey_ext[COORD_BITS-1:0];
		xneg_c  = (x1_c < x0_c);
		yneg_c  = (y1_c < y0_c);
		adx_c   = xneg_c ? (x0_c - x1_c) : (x1_c - x0_c);
		ady_c   = yneg_c ? (y0_c - y1_c) : (y1_c - y0_c);
		n_c     = (adx_c > ady_c) ? adx_c : ady_c;
		n_ext   = NEXT_W'(n_c);
		n_steps = n_ext[STEPS_W-1:0];
		x0_pix  = EXT_W'(x0_c);
		y0_pix  = EXT_W'(y0_c);
	end

	// Advance: add sign-extended increments, wrap in ACC_W bits, truncate.
	always_comb begin
		x_acc_n   = x_acc_q + {{(ACC_W-STEP_W){x_step_q[STEP_W-1]}}, x_step_q};
		y_acc_n   = y_acc_q + {{(ACC_W-STEP_W){y_step_q[STEP_W-1]}}, y_step_q};
		steps_dec = steps_q - 1'b1;
		adv_ok    = active_q && (steps_q != '0);
		adv_last  = (steps_dec == '0);
		xa_pix    = EXT_W'(x_acc_n[ACC_W-1:FRAC_BITS]);
		ya_pix    = EXT_W'(y_acc_n[ACC_W-1:FRAC_BITS]);
	end

	// Round the quotient: toward +inf for a rising delta (ceil), and the
	// negated floor for a falling one.
	always_comb begin
		div_mag  = (state_q == S_DIVY) ? ady_q : adx_q;
		div_neg  = (state_q == S_DIVY) ? yneg_q : xneg_q;
		q_ext    = STEP_W'(div_quot);
		step_fix = div_neg ? (~q_ext + STEP_W'(1)) : (q_ext + STEP_W'(div_stat.rem_nz));
	end

	dda_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.mag    (div_mag),
		.den    (n_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			colour_q    <= COLOUR_RESET;
		end else begin
			go_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				colour_q <= cfg.pixel_colour;
			end
			if (cmd_acc) begin
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (is_start) begin
							active_q <= (n_c != '0);
							if (n_c != '0) begin
								state_q <= S_DIVX;
								go_q    <= 1'b1;
							end
						end else begin
							// drop the line after its last pixel, or on a stray advance
							active_q <= adv_ok && !adv_last;
						end
					end
				end
				S_DIVX: begin
					if (div_stat.done) begin
						state_q <= S_DIVY;
						go_q    <= 1'b1;
					end
				end
				S_DIVY: begin
					if (div_stat.done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_DIVX && div_stat.done) begin
			x_step_q <= step_fix;
		end
		if (state_q == S_DIVY && div_stat.done) begin
			y_step_q <= step_fix;
		end
		if (cmd_acc) begin
			if (is_start) begin
				x_acc_q  <= {x0_c, {FRAC_BITS{1'b0}}};
				y_acc_q  <= {y0_c, {FRAC_BITS{1'b0}}};
				adx_q    <= adx_c;
				ady_q    <= ady_c;
				n_q      <= n_c;
				xneg_q   <= xneg_c;
				yneg_q   <= yneg_c;
				steps_q  <= n_steps;
				x_step_q <= '0;
				y_step_q <= '0;
				pv_q     <= 1'b1;
				px_q     <= x0_pix[PIX_W-1:0];
				py_q     <= y0_pix[PIX_W-1:0];
				pc_q     <= colour_q;
				pl_q     <= (n_c == '0);
			end else if (adv_ok) begin
				x_acc_q <= x_acc_n;
				y_acc_q <= y_acc_n;
				steps_q <= steps_dec;
				pv_q    <= 1'b1;
				px_q    <= xa_pix[PIX_W-1:0];
				py_q    <= ya_pix[PIX_W-1:0];
				pc_q    <= colour_q;
				pl_q    <= adv_last;
			end else begin
				// advance with no line: empty item
				pv_q <= 1'b0;
				px_q <= '0;
				py_q <= '0;
				pc_q <= '0;
				pl_q <= 1'b0;
			end
		end
	end

	assign pix.valid            = out_valid_q;
	assign pix.pixel_valid      = pv_q;
	assign pix.pixel_x          = px_q;
	assign pix.pixel_y          = py_q;
	assign pix.pixel_colour_out = pc_q;
	assign pix.last_pixel       = pl_q;

	a_start_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && is_start && n_c != '0) |=> (state_q == S_DIVX))
		else $error("start of a non-empty line did not launch the divider");
	a_div_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q != S_IDLE))
		else $error("divider finished while sequencer idle");
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && !is_start && active_q && steps_q == STEPS_W'(1))
		|=> (!active_q && pix.last_pixel && pix.pixel_valid))
		else $error("final advance did not flag last pixel");

endmodule

>>> rtl/core/dda_div.sv
`timescale 1ns / 1ps

module dda_div #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [COORD_BITS-1:0]  mag,
	input  logic [COORD_BITS-1:0]  den,
	output logic [FRAC_BITS:0]     quot,
	output dda_pkg::div_stat_t     stat
);
	import dda_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_BITS:0]   rem_q;
	logic [FRAC_BITS:0]    quot_q;
	logic                  done_q;
	logic                  rem_nz_q;

	logic [COORD_BITS+1:0] diff;
	logic                  ge;
	logic [COORD_BITS:0]   rem_nxt;

	// One restoring step: mag <= den, so the integer bit comes first and
	// FRAC_BITS fraction bits follow.
	always_comb begin
		diff    = {1'b0, rem_q} - {2'b00, den};
		ge      = ~diff[COORD_BITS+1];
		rem_nxt = ge ? diff[COORD_BITS:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, mag};
		end else if (busy_q) begin
			quot_q   <= {quot_q[FRAC_BITS-1:0], ge};
			rem_q    <= {rem_nxt[COORD_BITS-1:0], 1'b0};
			rem_nz_q <= (rem_nxt != '0);
		end
	end

	assign quot        = quot_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = rem_nz_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n) go |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !go && cnt_q == '0) |=> (done_q && !busy_q))
		else $error("divider missed its done pulse");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import dda_pkg::*;

	localparam int FRAC   = FRAC_BITS_DEF;
	localparam int ACC_W  = COORD_BITS_DEF + FRAC_BITS_DEF;
	localparam int STEP_W = FRAC_BITS_DEF + 2;
	localparam int COORD_MAX = (1 << PIX_W) - 1;

	// Give up well past the slowest correct run: every start waits out the divider,
	// every pixel waits out the longest stall, plus the long hold-off.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Divider run after a start, with margin; used before colour writes and at the end.
	localparam int DRAIN_CYCLES = 2 * FRAC_BITS_DEF + 32;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		op_t             op;
		logic [PIX_W-1:0] start_x;
		logic [PIX_W-1:0] start_y;
		logic [PIX_W-1:0] end_x;
		logic [PIX_W-1:0] end_y;
	} line_cmd_t;

	typedef struct packed {
		logic                pixel_valid;
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    y;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} pixel_t;

	// Tracks the line being walked and queues the pixel each command should return.
	class pixel_scoreboard;
		pixel_t              pixels_due[$];
		int                  errors;
		logic [ACC_W-1:0]    x_pos;
		logic [ACC_W-1:0]    y_pos;
		logic [STEP_W-1:0]   x_inc;
		logic [STEP_W-1:0]   y_inc;
		logic [STEPS_W-1:0]  pixels_left;
		bit                  drawing;
		logic [COLOUR_W-1:0] colour;

		function new();
			x_pos       = '0;
			y_pos       = '0;
			x_inc       = '0;
			y_inc       = '0;
			pixels_left = '0;
			drawing     = 1'b0;
			colour      = COLOUR_RESET;
			errors      = 0;
		endfunction

		function void set_colour(logic [COLOUR_W-1:0] c);
			colour = c;
		endfunction

		// Rising increments round up, falling ones round toward zero before negation,
		// so the position never lags the true line.
		function logic [STEP_W-1:0] slope(logic [PIX_W-1:0] from_c, logic [PIX_W-1:0] to_c,
				longint unsigned n);
			longint unsigned num;
			longint unsigned q;
			if (to_c >= from_c) begin
				num = 64'(to_c) - 64'(from_c);
				num = num << FRAC;
				q = (num + n - 1) / n;
			end else begin
				num = 64'(from_c) - 64'(to_c);
				num = num << FRAC;
				q = 64'd0 - (num / n);
			end
			return q[STEP_W-1:0];
		endfunction

		function pixel_t plot(bit last);
			pixel_t p;
			p.pixel_valid = 1'b1;
			p.x           = x_pos[FRAC +: PIX_W];
			p.y           = y_pos[FRAC +: PIX_W];
			p.colour      = colour;
			p.last        = last;
			return p;
		endfunction

		function void note_cmd(line_cmd_t c);
			logic [PIX_W-1:0] adx;
			logic [PIX_W-1:0] ady;
			longint unsigned  n;
			pixel_t           p;
			if (c.op == OP_START) begin
				adx = (c.end_x >= c.start_x) ? c.end_x - c.start_x : c.start_x - c.end_x;
				ady = (c.end_y >= c.start_y) ? c.end_y - c.start_y : c.start_y - c.end_y;
				n = 64'((adx > ady) ? adx : ady);
				x_pos = {c.start_x, {FRAC{1'b0}}};
				y_pos = {c.start_y, {FRAC{1'b0}}};
				if (n == 0) begin
					x_inc       = '0;
					y_inc       = '0;
					pixels_left = '0;
					drawing     = 1'b0;
					p = plot(1'b1);
				end else begin
					x_inc       = slope(c.start_x, c.end_x, n);
					y_inc       = slope(c.start_y, c.end_y, n);
					pixels_left = n[STEPS_W-1:0];
					drawing     = 1'b1;
					p = plot(1'b0);
				end
			end else if (!drawing || pixels_left == 0) begin
				drawing = 1'b0;
				p = '0;
			end else begin
				x_pos = x_pos + {{(ACC_W-STEP_W){x_inc[STEP_W-1]}}, x_inc};
				y_pos = y_pos + {{(ACC_W-STEP_W){y_inc[STEP_W-1]}}, y_inc};
				pixels_left = pixels_left - 1'b1;
				if (pixels_left == 0) begin
					drawing = 1'b0;
					p = plot(1'b1);
				end else begin
					p = plot(1'b0);
				end
			end
			pixels_due.push_back(p);
		endfunction

		task report_mismatch(string what, int want, int got);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		endtask

		task check_pix(pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				report_mismatch("unexpected pixel (x)", -1, int'(got.x));
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_valid !== want.pixel_valid)
				report_mismatch("pixel_valid", int'(want.pixel_valid), int'(got.pixel_valid));
			if (got.x !== want.x)
				report_mismatch("pixel_x", int'(want.x), int'(got.x));
			if (got.y !== want.y)
				report_mismatch("pixel_y", int'(want.y), int'(got.y));
			if (got.colour !== want.colour)
				report_mismatch("pixel_colour_out", int'(want.colour), int'(got.colour));
			if (got.last !== want.last)
				report_mismatch("last_pixel", int'(want.last), int'(got.last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	dda_cmd_if cmd_bus ();
	dda_pix_if pix_bus ();
	dda_cfg_if cfg_bus ();

	dda_line_rasterizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.pix    (pix_bus),
		.cfg    (cfg_bus)
	);

	pixel_scoreboard board = new();

	int          send_gap_pct;   // chance in 100 that the command side idles a cycle
	int          stall_pct;      // chance in 100 that the pixel side stalls a cycle
	int          items_sent;
	int          hold_left;
	bit          hold_request;
	int unsigned cycles;

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Pixel side: random back-pressure, or a long hold-off when asked for. The hold-off
	// is counted here so the command side keeps pushing until the core backs up.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_OFF_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			pix_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			pix_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Sample every pixel handed over and check it against the oldest one due
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			got.pixel_valid = pix_bus.pixel_valid;
			got.x           = pix_bus.pixel_x;
			got.y           = pix_bus.pixel_y;
			got.colour      = pix_bus.pixel_colour_out;
			got.last        = pix_bus.last_pixel;
			board.check_pix(got);
		end
	end

	// Offer one command; entered and left at a falling edge. Valid stays high on exit
	// so back-to-back items need no extra assignment in the same step.
	task automatic send_cmd(line_cmd_t c);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid   <= 1'b1;
		cmd_bus.op      <= c.op;
		cmd_bus.start_x <= c.start_x;
		cmd_bus.start_y <= c.start_y;
		cmd_bus.end_x   <= c.end_x;
		cmd_bus.end_y   <= c.end_y;
		do @(posedge clk); while (!cmd_bus.ready);
		board.note_cmd(c);
		items_sent++;
		@(negedge clk);
	endtask

	// One advance item; its coordinates are random and the core must ignore them.
	task automatic send_advance();
		line_cmd_t c;
		c.op      = OP_ADVANCE;
		c.start_x = PIX_W'($urandom());
		c.start_y = PIX_W'($urandom());
		c.end_x   = PIX_W'($urandom());
		c.end_y   = PIX_W'($urandom());
		send_cmd(c);
	endtask

	// Start a line, then advance it a given number of times.
	task automatic draw_line(int sx, int sy, int ex, int ey, int advances);
		line_cmd_t c;
		c.op      = OP_START;
		c.start_x = PIX_W'(sx);
		c.start_y = PIX_W'(sy);
		c.end_x   = PIX_W'(ex);
		c.end_y   = PIX_W'(ey);
		send_cmd(c);
		repeat (advances) send_advance();
	endtask

	// Drop valid, wait out every due pixel and then the divider, ending at a falling edge
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (board.pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_colour(logic [COLOUR_W-1:0] c);
		cfg_bus.valid        <= 1'b1;
		cfg_bus.pixel_colour <= c;
		do @(posedge clk); while (!cfg_bus.ready);
		board.set_colour(c);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic int near(int base, int reach);
		int lo;
		int hi;
		lo = (base - reach < 0) ? 0 : base - reach;
		hi = (base + reach > COORD_MAX) ? COORD_MAX : base + reach;
		return $urandom_range(hi, lo);
	endfunction

	// Mostly complete short lines; some longer, some cut off by a new start, some
	// walked past their end, a few spanning the whole field, and zero-length lines with stray advances.
	task automatic run_lines(int count);
		int stop_at;
		int roll;
		int reach;
		int sx, sy, ex, ey;
		int n;
		int adv;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				draw_line(0, 0, 0, 0, 0);
				draw_line(0, 0, 0, 0, 0);
			end
			if (roll < 6) begin
				// stray advances with no line running behind the zero-length ones
				repeat ($urandom_range(3, 1)) send_advance();
			end else begin
				sx = $urandom_range(COORD_MAX);
				sy = $urandom_range(COORD_MAX);
				if (roll < 85)
					reach = $urandom_range(16);
				else if (roll < 96)
					reach = $urandom_range(120);
				else
					reach = COORD_MAX;
				ex = near(sx, reach);
				ey = near(sy, reach);
				n = (ex > sx) ? ex - sx : sx - ex;
				if (((ey > sy) ? ey - sy : sy - ey) > n)
					n = (ey > sy) ? ey - sy : sy - ey;
				roll = $urandom_range(99);
				if (reach == COORD_MAX)
					adv = $urandom_range(40);
				else if (roll < 75)
					adv = n;
				else if (roll < 88)
					adv = n + $urandom_range(3, 1);
				else
					adv = $urandom_range(n);
				draw_line(sx, sy, ex, ey, adv);
			end
		end
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cmd_bus.valid        = 1'b0;
		cmd_bus.op           = OP_START;
		cmd_bus.start_x      = '0;
		cmd_bus.start_y      = '0;
		cmd_bus.end_x        = '0;
		cmd_bus.end_y        = '0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.pixel_colour = '0;
		pix_bus.ready        = 1'b0;
		send_gap_pct         = 0;
		stall_pct            = 0;
		items_sent           = 0;
		hold_left            = 0;
		hold_request         = 1'b0;
		cycles               = 0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, under the reset colour
		send_advance();                         // advance with nothing drawn since reset
		draw_line(0, 0, 0, 0, 0);               // zero-length line at the origin
		draw_line(0, 0, 0, 0, 0);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		draw_line(0, 0, COORD_MAX, COORD_MAX, 2);   // full diagonal, abandoned early
		draw_line(COORD_MAX, 0, 0, COORD_MAX, 2);   // anti-diagonal, abandoned too
		draw_line(100, 200, 103, 201, 4);       // shallow rise, one advance past the end
		draw_line(50, 50, 48, 45, 5);           // steep fall in both axes
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, 2);
		settle();

		// Advance while idle: the very first item of this block of the run
		write_colour('0);
		send_advance();
		run_lines(6);

		// No idling; hold the pixel side off so the core fills and stalls commands
		hold_request = 1'b1;
		run_lines(240);
		settle();

		write_colour({COLOUR_W{1'b1}});
		send_gap_pct = 66;
		stall_pct    = 0;
		run_lines(250);
		settle();

		write_colour(COLOUR_W'($urandom_range((1 << COLOUR_W) - 1)));
		send_gap_pct = 0;
		stall_pct    = 66;
		run_lines(250);
		settle();

		write_colour(COLOUR_W'($urandom_range((1 << COLOUR_W) - 1)));
		send_gap_pct = 21;
		stall_pct    = 21;
		run_lines(250);
		settle();

		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
